/* src/cal_clk_pkg.sv */
`default_nettype none

package cal_clk_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_TWELVE_HOUR = 3'd0;
    localparam logic [2:0] REG_ALARM_EN    = 3'd1;
    localparam logic [2:0] REG_ALARM_HOUR  = 3'd2;
    localparam logic [2:0] REG_ALM_MINUTE  = 3'd3;
    localparam logic [2:0] REG_ALARM_PM    = 3'd4;

    // Request codes.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Reset date and time.
    localparam logic [13:0] RST_YEAR   = 14'd1700;
    localparam logic [3:0]  RST_MONTH  = 4'd2;
    localparam logic [4:0]  RST_DAY    = 5'd28;
    localparam logic [4:0]  RST_HOUR   = 5'd11;
    localparam logic [5:0]  RST_MINUTE = 6'd49;
    localparam logic [5:0]  RST_SECOND = 6'd50;
    localparam logic        RST_PM     = 1'b1;

    localparam logic [13:0] YEAR_LAST = 14'd9999;

    // Multiplicative inverse of 25 modulo 2^14 and the largest quotient.
    // A 14-bit value is a multiple of 25 exactly when its product with the
    // inverse, kept to 14 bits, does not exceed 16383 / 25.
    localparam logic [13:0] INV_25   = 14'd7209;
    localparam logic [13:0] LIMIT_25 = 14'd655;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        pm;
    } t_time;

    function automatic logic is_mult_25(input logic [13:0] y);
        logic [27:0] prod;
        begin
            prod = y * INV_25;
            return prod[13:0] <= LIMIT_25;
        end
    endfunction

    // Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
    function automatic logic is_leap(input logic [13:0] y);
        logic m25;
        begin
            m25 = is_mult_25(y);
            return (y[1:0] == 2'd0 && !m25) || (y[3:0] == 4'd0 && m25);
        end
    endfunction

    // Days in a month; codes outside 1..12 count as 30-day months.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd2:                                   len = leap ? 5'd29 : 5'd28;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                default:                                len = 5'd30;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

/* src/calendar_clock_with_alarm.sv */
// Calendar clock with alarm.
// Input channel (i_in_valid / o_in_stall): each transaction is either a
// one-second tick or a load of the whole date and time (i_req_type).
// Output channel (o_out_valid / i_out_stall): exactly one transaction per
// input transaction, carrying the date and time after the update and the
// alarm flag, in the same order as the inputs.
// The result of an accepted transaction is registered and presented in the
// cycle after its acceptance. Throughput is one transaction per cycle while
// the output is not stalled; the whole carry chain from second to year and
// the alarm compare sit in one combinational step between the time registers
// and the result register. When the receiver stalls, the result register
// holds its contents and the input stalls only while it is full and stalled.
// Configuration registers are set by i_cfg_wr_en, i_cfg_index, i_cfg_data;
// the user must do so only while the block is idle; the block does not check.
// Reset (synchronous, active low) sets the time to 1700-02-28 11:49:50 PM,
// twelve-hour mode, alarm disabled, and empties the result register.
`default_nettype none

module calendar_clock_with_alarm
    import cal_clk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [5:0]  i_cfg_data,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [13:0] i_load_year,
    input  wire logic [3:0]  i_load_month,
    input  wire logic [4:0]  i_load_day,
    input  wire logic [4:0]  i_load_hour,
    input  wire logic [5:0]  i_load_minute,
    input  wire logic [5:0]  i_load_second,
    input  wire logic        i_load_pm,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [13:0]      o_cur_year,
    output logic [3:0]       o_cur_month,
    output logic [4:0]       o_cur_day,
    output logic [4:0]       o_cur_hour,
    output logic [5:0]       o_cur_minute,
    output logic [5:0]       o_cur_second,
    output logic             o_cur_pm,
    output logic             o_alarm_hit
);

    // Configuration registers.
    logic       r_twelve_hour;
    logic       r_alarm_en;
    logic [4:0] r_alarm_hour;
    logic [5:0] r_alm_minute;
    logic       r_alarm_pm;

    // Time state and result register.
    t_time r_time;
    t_time n_time;
    t_time r_res;
    logic  r_res_hit;
    logic  r_out_valid;
    logic  n_hit;
    logic  in_accept;

    // Working values, wide enough to hold one increment past the field range.
    logic [6:0]  sec_w;
    logic [6:0]  min_w;
    logic [5:0]  hour_w;
    logic [5:0]  day_w;
    logic [4:0]  mon_w;
    logic [13:0] year_w;
    logic        pm_w;
    logic        to_noon;
    logic [4:0]  mon_len;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_twelve_hour <= 1'b1;
            r_alarm_en    <= 1'b0;
            r_alarm_hour  <= 5'd0;
            r_alm_minute  <= 6'd0;
            r_alarm_pm    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_TWELVE_HOUR: r_twelve_hour <= i_cfg_data[0];
                REG_ALARM_EN:    r_alarm_en    <= i_cfg_data[0];
                REG_ALARM_HOUR:  r_alarm_hour  <= i_cfg_data[4:0];
                REG_ALM_MINUTE:  r_alm_minute  <= i_cfg_data;
                REG_ALARM_PM:    r_alarm_pm    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // One-second carry chain from second up to year.
    always_comb begin
        to_noon = 1'b0;
        sec_w   = {1'b0, r_time.second} + 7'd1;
        min_w   = {1'b0, r_time.minute};
        hour_w  = {1'b0, r_time.hour};
        day_w   = {1'b0, r_time.day};
        mon_w   = {1'b0, r_time.month};
        year_w  = r_time.year;
        pm_w    = r_time.pm;

        if (sec_w >= 7'd60) begin
            sec_w = 7'd0;
            min_w = min_w + 7'd1;
        end
        if (min_w >= 7'd60) begin
            min_w   = 7'd0;
            hour_w  = hour_w + 6'd1;
            to_noon = (hour_w == 6'd12);
        end

        if (r_twelve_hour) begin
            if (hour_w > 6'd12) begin
                hour_w = 6'd1;
            end
            // Noon turns AM to PM; midnight turns PM to AM on the next day.
            if (to_noon) begin
                if (pm_w) begin
                    pm_w  = 1'b0;
                    day_w = day_w + 6'd1;
                end else begin
                    pm_w = 1'b1;
                end
            end
        end else if (hour_w >= 6'd24) begin
            hour_w = 6'd0;
            day_w  = day_w + 6'd1;
        end

        mon_len = month_days(r_time.month, is_leap(r_time.year));
        if (day_w > {1'b0, mon_len}) begin
            day_w = 6'd1;
            mon_w = mon_w + 5'd1;
        end
        if (mon_w > 5'd12) begin
            mon_w  = 5'd1;
            year_w = (r_time.year >= YEAR_LAST) ? 14'd0 : r_time.year + 14'd1;
        end
    end

    // Next time: a load overwrites every field, a tick takes the carry chain.
    always_comb begin
        if (i_req_type == REQ_LOAD) begin
            n_time.year   = i_load_year;
            n_time.month  = i_load_month;
            n_time.day    = i_load_day;
            n_time.hour   = i_load_hour;
            n_time.minute = i_load_minute;
            n_time.second = i_load_second;
            n_time.pm     = i_load_pm;
        end else begin
            n_time.year   = year_w;
            n_time.month  = mon_w[3:0];
            n_time.day    = day_w[4:0];
            n_time.hour   = hour_w[4:0];
            n_time.minute = min_w[5:0];
            n_time.second = sec_w[5:0];
            n_time.pm     = pm_w;
        end
    end

    // Alarm compare on the updated time.
    assign n_hit = r_alarm_en
                && n_time.hour == r_alarm_hour
                && n_time.minute == r_alm_minute
                && n_time.second >= 6'd1 && n_time.second <= 6'd30
                && (!r_twelve_hour || n_time.pm == r_alarm_pm);

    // Time state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.year   <= RST_YEAR;
            r_time.month  <= RST_MONTH;
            r_time.day    <= RST_DAY;
            r_time.hour   <= RST_HOUR;
            r_time.minute <= RST_MINUTE;
            r_time.second <= RST_SECOND;
            r_time.pm     <= RST_PM;
        end else if (in_accept) begin
            r_time <= n_time;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; the half-of-day field reads 0 in 24-hour mode.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res.year   <= n_time.year;
            r_res.month  <= n_time.month;
            r_res.day    <= n_time.day;
            r_res.hour   <= n_time.hour;
            r_res.minute <= n_time.minute;
            r_res.second <= n_time.second;
            r_res.pm     <= r_twelve_hour && n_time.pm;
            r_res_hit    <= n_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cur_year   = r_res.year;
    assign o_cur_month  = r_res.month;
    assign o_cur_day    = r_res.day;
    assign o_cur_hour   = r_res.hour;
    assign o_cur_minute = r_res.minute;
    assign o_cur_second = r_res.second;
    assign o_cur_pm     = r_res.pm;
    assign o_alarm_hit  = r_res_hit;

    // An accepted transaction always leaves a result waiting.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // A raised alarm implies the alarm is enabled.
    a_alarm_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_hit) |-> r_alarm_en)
        else $error("alarm raised while disabled");

    // A raised alarm only falls within seconds 1 to 30 of the minute.
    a_alarm_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_hit) |-> (o_cur_second >= 6'd1 && o_cur_second <= 6'd30))
        else $error("alarm raised outside its second window");

    // A tick below the last second simply advances the second.
    a_second_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req_type == REQ_TICK && r_time.second < 6'd59)
        |=> r_time.second == $past(r_time.second) + 6'd1)
        else $error("second did not advance by one");

endmodule

`default_nettype wire
